// ===== hdl/spe_pkg.sv =====
`timescale 1ns / 1ps

package spe_pkg;

  localparam int MAX_PATCH_DEF = 8;
  localparam int MAX_WIDTH_DEF = 256;

  localparam int PIX_W      = 8;
  localparam int VALUE_W    = 16;
  localparam int ELEM_W     = 6;
  localparam int COLUMN_W   = 20;
  localparam int ROWS_W     = 9;
  localparam int COLS_W     = 9;
  localparam int PSIZE_W    = 4;
  localparam int PIDX_W     = 3;   // row/column/slot index inside a patch, patch side up to 8
  localparam int ROWPOS_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam int OUT_DATA_W = 48;  // value, element, column padded to whole bytes

  localparam logic [ROWS_W-1:0]   ROWS_RESET  = 9'd16;
  localparam logic [COLS_W-1:0]   COLS_RESET  = 9'd16;
  localparam logic [PSIZE_W-1:0]  PSIZE_RESET = 4'd8;
  localparam logic [COLUMN_W-1:0] START_RESET = 20'd0;

  typedef logic [CFG_IDX_W-1:0] cfg_addr_t;
  localparam cfg_addr_t CFG_IMAGE_ROWS   = 2'd0;
  localparam cfg_addr_t CFG_IMAGE_COLS   = 2'd1;
  localparam cfg_addr_t CFG_PATCH_SIZE   = 2'd2;
  localparam cfg_addr_t CFG_START_COLUMN = 2'd3;

  typedef struct packed {
    logic [ROWS_W-1:0]   image_rows;
    logic [COLS_W-1:0]   image_cols;
    logic [PSIZE_W-1:0]  patch_size;
    logic [COLUMN_W-1:0] start_column;
  } cfg_t;

  // Tag that travels with one line store read
  typedef struct packed {
    logic [ELEM_W-1:0]   element;
    logic [COLUMN_W-1:0] column;
    logic                last;
  } rd_meta_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

endpackage

// ===== hdl/spe_line_store.sv =====
`timescale 1ns / 1ps

module spe_line_store import spe_pkg::*; #(
  parameter int DEPTH = MAX_PATCH_DEF * MAX_WIDTH_DEF,
  parameter int AW    = $clog2(MAX_PATCH_DEF * MAX_WIDTH_DEF)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [PIX_W-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [PIX_W-1:0] rd_data
);

  logic [PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/spe_ctrl.sv =====
`timescale 1ns / 1ps

module spe_ctrl import spe_pkg::*; #(
  parameter int MAX_PATCH = MAX_PATCH_DEF,
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [PIX_W-1:0]    pixel,
  input  logic                image_start,
  input  logic                issue_ok,
  output logic                wr_en,
  output logic [$clog2(MAX_PATCH*MAX_WIDTH)-1:0] wr_addr,
  output logic [PIX_W-1:0]    wr_data,
  output logic                rd_en,
  output logic [$clog2(MAX_PATCH*MAX_WIDTH)-1:0] rd_addr,
  output rd_meta_t            rd_meta
);

  localparam int AW  = $clog2(MAX_PATCH * MAX_WIDTH);
  localparam int CW  = (MAX_WIDTH >= 256) ? 8 : $clog2(MAX_WIDTH);
  localparam int CAP = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;

  state_t state, state_next;

  // Raster position and line store slot of the next pixel
  logic [ROWPOS_W-1:0] row;
  logic [CW-1:0]       col;
  logic [PIDX_W-1:0]   slot;
  logic [COLUMN_W-1:0] cnt;

  // Patch read sequencer
  logic [PIDX_W-1:0]   u, v, rslot, pm1_q;
  logic [CW-1:0]       cbase;
  logic [ELEM_W-1:0]   elem;
  logic [COLUMN_W-1:0] ecol;

  logic [ROWS_W-1:0]   rows9;
  logic [COLS_W-1:0]   cols9;
  logic [PSIZE_W-1:0]  p4;
  logic [PIDX_W-1:0]   pm1;
  logic [ROWPOS_W-1:0] rs0, rs1, rs2, row_n;
  logic [CW-1:0]       cs0, cs2, col_n;
  logic [PIDX_W-1:0]   ss0, ss1, ss2, slot_n, sslot;
  logic [COLUMN_W-1:0] col_out, cnt_n;
  logic                hit, accept, last_el;

  function automatic logic [PIDX_W-1:0] slot_inc(input logic [PIDX_W-1:0] s);
    slot_inc = (s == PIDX_W'(MAX_PATCH - 1)) ? '0 : s + PIDX_W'(1);
  endfunction

  // Clamp registers, place the pixel, work out whether it closes a patch
  always_comb begin
    if (cfg.image_rows == '0)             rows9 = 9'd1;
    else if (cfg.image_rows > 9'd256)     rows9 = 9'd256;
    else                                  rows9 = cfg.image_rows;
    if (cfg.image_cols == '0)             cols9 = 9'd1;
    else if (cfg.image_cols > 9'(CAP))    cols9 = 9'(CAP);
    else                                  cols9 = cfg.image_cols;
    if (cfg.patch_size == '0)                    p4 = 4'd1;
    else if (cfg.patch_size > 4'(MAX_PATCH))     p4 = 4'(MAX_PATCH);
    else                                         p4 = cfg.patch_size;
    pm1 = PIDX_W'(p4 - 4'd1);

    rs0 = image_start ? '0 : row;
    cs0 = image_start ? '0 : col;
    ss0 = image_start ? '0 : slot;

    if (9'(rs0) >= rows9) begin
      rs1 = '0;
      ss1 = '0;
    end else begin
      rs1 = rs0;
      ss1 = ss0;
    end

    if (9'(cs0) >= cols9) begin
      cs2 = '0;
      if (9'(rs1) + 9'd1 >= rows9) begin
        rs2 = '0;
        ss2 = '0;
      end else begin
        rs2 = rs1 + 8'd1;
        ss2 = slot_inc(ss1);
      end
    end else begin
      cs2 = cs0;
      rs2 = rs1;
      ss2 = ss1;
    end

    hit = (rs2 >= ROWPOS_W'(pm1)) && (9'(cs2) >= 9'(pm1));

    if (ss2 >= pm1) sslot = ss2 - pm1;
    else            sslot = PIDX_W'(4'(ss2) + 4'(MAX_PATCH) - 4'(pm1));

    // Advance past this pixel
    if (9'(cs2) + 9'd1 >= cols9) begin
      col_n = '0;
      if (9'(rs2) + 9'd1 >= rows9) begin
        row_n  = '0;
        slot_n = '0;
      end else begin
        row_n  = rs2 + 8'd1;
        slot_n = slot_inc(ss2);
      end
    end else begin
      col_n  = cs2 + CW'(1);
      row_n  = rs2;
      slot_n = ss2;
    end

    col_out = image_start ? cfg.start_column : cnt;
    cnt_n   = hit ? col_out + COLUMN_W'(1) : col_out;
  end

  assign last_el = (u == pm1_q) && (v == pm1_q);

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    rd_en      = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && hit) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        rd_en = issue_ok;
        if (issue_ok && last_el) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign accept  = in_valid && in_ready;
  assign wr_en   = accept;
  assign wr_data = pixel;
  assign wr_addr = AW'(ss2) * AW'(MAX_WIDTH) + AW'(cs2);
  assign rd_addr = AW'(rslot) * AW'(MAX_WIDTH) + AW'(cbase) + AW'(v);
  assign rd_meta = '{element: elem, column: ecol, last: last_el};

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row  <= '0;
      col  <= '0;
      slot <= '0;
      cnt  <= START_RESET;
    end else if (accept) begin
      row  <= row_n;
      col  <= col_n;
      slot <= slot_n;
      cnt  <= cnt_n;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hit) begin
      u     <= '0;
      v     <= '0;
      elem  <= '0;
      rslot <= sslot;
      cbase <= cs2 - CW'(pm1);
      pm1_q <= pm1;
      ecol  <= col_out;
    end else if (rd_en) begin
      elem <= elem + ELEM_W'(1);
      if (v == pm1_q) begin
        v     <= '0;
        u     <= u + PIDX_W'(1);
        rslot <= slot_inc(rslot);
      end else begin
        v <= v + PIDX_W'(1);
      end
    end
  end

endmodule

// ===== hdl/spe_out_buf.sv =====
`timescale 1ns / 1ps

module spe_out_buf import spe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rd_fire,
  input  rd_meta_t              rd_meta,
  input  logic [PIX_W-1:0]      rd_data,
  output logic                  issue_ok,
  output logic                  tvalid,
  input  logic                  tready,
  output logic [OUT_DATA_W-1:0] tdata,
  output logic                  tlast
);

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    rd_meta_t         meta;
  } out_item_t;

  out_item_t buf_q [2];
  rd_meta_t  meta_d;
  logic      inflight;
  logic      wr_ptr, rd_ptr;
  logic [1:0] count;
  logic      pop;
  out_item_t head;

  assign head   = buf_q[rd_ptr];
  assign tvalid = (count != 2'd0);
  assign pop    = tvalid && tready;
  // Keep room for every read already in flight
  assign issue_ok = (3'(count) - 3'(pop) + 3'(inflight)) < 3'd2;

  assign tdata = {(OUT_DATA_W - VALUE_W - ELEM_W - COLUMN_W)'(0),
                  head.meta.column, head.meta.element, head.pix, head.pix};
  assign tlast = head.meta.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= 1'b0;
      wr_ptr   <= 1'b0;
      rd_ptr   <= 1'b0;
      count    <= 2'd0;
    end else begin
      inflight <= rd_fire;
      if (inflight) wr_ptr <= ~wr_ptr;
      if (pop)      rd_ptr <= ~rd_ptr;
      count <= count + 2'(inflight) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_fire) meta_d <= rd_meta;
    if (inflight) buf_q[wr_ptr] <= '{pix: rd_data, meta: meta_d};
  end

endmodule

// ===== hdl/sliding_patch_extractor.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Payload
// s_axis    in         tdata[7:0] pixel; tuser[0] image_start
// m_axis    out        tdata[15:0] value, [21:16] element, [41:22] column; tlast last
// cfg       in         cfg_index selects register, cfg_data holds the new value
//
// A pixel that closes no patch leaves s_axis ready for the next one. A pixel
// that closes a patch holds s_axis until its patch_size^2 elements are read;
// the single line store read port gives one element per cycle unless held.
// Reset clears positions and the patch counter; the line store is not cleared.
// A stall on m_axis holds the element reads; a two-word output buffer keeps
// full rate while the sink takes a word every cycle.

module sliding_patch_extractor import spe_pkg::*; #(
  parameter int MAX_PATCH = MAX_PATCH_DEF,
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] pixel
  input  logic [0:0]            s_axis_tuser,   // [0] image_start
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [15:0] value, [21:16] element,
                                                // [41:22] column, [47:42] zero
  output logic                  m_axis_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH = MAX_PATCH * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);

  cfg_t             cfg;
  logic             wr_en, rd_en, issue_ok;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic [PIX_W-1:0] wr_data, rd_data;
  rd_meta_t         rd_meta;

  // Registers take a word on every cycle; the user must write only while idle, as the block does not enforce it
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_rows   <= ROWS_RESET;
      cfg.image_cols   <= COLS_RESET;
      cfg.patch_size   <= PSIZE_RESET;
      cfg.start_column <= START_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_IMAGE_ROWS:   cfg.image_rows   <= cfg_data[ROWS_W-1:0];
        CFG_IMAGE_COLS:   cfg.image_cols   <= cfg_data[COLS_W-1:0];
        CFG_PATCH_SIZE:   cfg.patch_size   <= cfg_data[PSIZE_W-1:0];
        CFG_START_COLUMN: cfg.start_column <= cfg_data[COLUMN_W-1:0];
        default: ;
      endcase
    end
  end

  // Position tracking, pixel write and patch read sequencing
  spe_ctrl #(
    .MAX_PATCH (MAX_PATCH),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .pixel       (s_axis_tdata),
    .image_start (s_axis_tuser[0]),
    .issue_ok    (issue_ok),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_meta     (rd_meta)
  );

  // Most recent MAX_PATCH rows, one slot per row modulo MAX_PATCH
  spe_line_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Pair read data with its tag and buffer words for the sink
  spe_out_buf u_out (
    .clk      (clk),
    .rst      (rst),
    .rd_fire  (rd_en),
    .rd_meta  (rd_meta),
    .rd_data  (rd_data),
    .issue_ok (issue_ok),
    .tvalid   (m_axis_tvalid),
    .tready   (m_axis_tready),
    .tdata    (m_axis_tdata),
    .tlast    (m_axis_tlast)
  );

endmodule
